FILE: sv/bccm_pkg.sv
// Shared types, constants and saturation helpers for the closed-curve measure block.
// No dependencies; boundary_closed_curve_measure imports it.
package bccm_pkg;

  localparam int FRAC_BITS      = 4;
  localparam int COORD_INT_BITS = 12;
  localparam int COORD_W        = COORD_INT_BITS + FRAC_BITS;
  localparam int CFG_W          = 12;
  localparam int LEN_W          = 36;
  localparam int SHOE_W         = 36;
  localparam int AREA_W         = 34;
  localparam int SQ_W           = 2 * COORD_W + 2;   // dx^2 + dy^2
  localparam int MUL_W          = COORD_W + 2;       // signed multiplier operand
  localparam int PROD_W         = 2 * MUL_W;
  localparam int LEG_W          = COORD_W + 3;       // signed leg added to the length sum
  localparam int MOVE_W         = 3;

  localparam logic [MOVE_W-1:0] MAX_MOVES = 3'd5;
  localparam logic [CFG_W-1:0]  IMAGE_SIZE_RESET = 12'd256;

  // register indexes of the configuration port
  localparam logic REG_IMAGE_HEIGHT = 1'b0;
  localparam logic REG_IMAGE_WIDTH  = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DX    = 8'b0000_0010,
    S_DY    = 8'b0000_0100,
    S_SH    = 8'b0000_1000,
    S_SQRT  = 8'b0001_0000,
    S_LEN   = 8'b0010_0000,
    S_WALK  = 8'b0100_0000,
    S_WSHOE = 8'b1000_0000
  } state_t;

  // Length sum plus a signed leg, clamped to [0, 2^LEN_W - 1].
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] acc,
                                               input logic signed [LEG_W-1:0] leg);
    logic signed [LEN_W+1:0] s;
    s = $signed({2'b00, acc}) + $signed({{(LEN_W+2-LEG_W){leg[LEG_W-1]}}, leg});
    if (s[LEN_W+1])    return '0;
    else if (s[LEN_W]) return '1;
    else               return s[LEN_W-1:0];
  endfunction

  // Shoelace sum plus a signed term, clamped to the signed SHOE_W range.
  function automatic logic signed [SHOE_W-1:0] sat_shoe(
      input logic signed [SHOE_W-1:0] acc, input logic signed [SHOE_W:0] term);
    logic signed [SHOE_W+1:0] s;
    s = $signed({{2{acc[SHOE_W-1]}}, acc}) + $signed({term[SHOE_W], term});
    if (s[SHOE_W+1] == s[SHOE_W] && s[SHOE_W] == s[SHOE_W-1]) return s[SHOE_W-1:0];
    else if (s[SHOE_W+1]) return {1'b1, {(SHOE_W-1){1'b0}}};
    else                  return {1'b0, {(SHOE_W-1){1'b1}}};
  endfunction

  // floor(shoelace / 2), clamped to the signed AREA_W range.
  function automatic logic signed [AREA_W-1:0] area_of(input logic signed [SHOE_W-1:0] shoe);
    logic signed [SHOE_W-2:0] half;
    half = shoe[SHOE_W-1:1];
    if (half[SHOE_W-2:AREA_W-1] == '0 || half[SHOE_W-2:AREA_W-1] == '1)
      return half[AREA_W-1:0];
    else if (half[SHOE_W-2]) return {1'b1, {(AREA_W-1){1'b0}}};
    else                     return {1'b0, {(AREA_W-1){1'b1}}};
  endfunction

endpackage

FILE: sv/boundary_closed_curve_measure.sv
// Top level of the closed-curve measure: perimeter and signed area of a vertex stream.
// Uses bccm_pkg for constants, the sequencer state type and saturation helpers.
//
// Usage:
//   Request channel: present x_coord, y_coord (unsigned, 4 fraction bits) and
//   last_vertex, raise start; the request is taken at a clock edge with start
//   high and busy low. The first vertex of a curve is only stored; unless it is
//   also the last, busy stays low. Every later vertex keeps busy high through
//   three passes through the shared 18x18 multiplier (dx^2, dy^2, shoelace term),
//   17 steps of the bit-serial square root and a step to add length and area.
//   A vertex with last_vertex set then closes the curve along the image
//   border one move at a time (at most five); a move up the right edge takes
//   an extra step, as its area term goes through the multiplier, and a last
//   step finishes; done pulses for one cycle in the cycle after that with
//   perimeter (4 fraction bits) and area (8 fraction bits), both saturated.
//   busy is already low while done is high, so the next curve may start then.
//   The receiver cannot stall: take perimeter and area while done is high.
//   Configuration: cfg_write, cfg_index (0 height, 1 width, in pixels) and
//   cfg_data; write only while idle between curves.
//   Reset (rst, synchronous) returns to idle, sets both image sizes to 256
//   and waits for the first vertex of a new curve.
module boundary_closed_curve_measure
  import bccm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [COORD_W-1:0]        x_coord,
  input  logic [COORD_W-1:0]        y_coord,
  input  logic                      last_vertex,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output logic                      done,
  output logic [LEN_W-1:0]          perimeter,
  output logic signed [AREA_W-1:0]  area
);

  state_t state;

  logic [CFG_W-1:0]   image_height;
  logic [CFG_W-1:0]   image_width;

  logic [COORD_W-1:0] start_x, start_y, prev_x, prev_y;
  logic [COORD_W-1:0] cur_x, cur_y;
  logic               cur_last;
  logic               awaiting_first;

  logic [LEN_W-1:0]          length_sum;
  logic signed [SHOE_W-1:0]  shoelace_sum;

  logic signed [PROD_W-1:0]  prod;
  logic [SQ_W-1:0]           rem;
  logic [SQ_W-1:0]           root;
  logic [SQ_W-1:0]           bitv;
  logic [MOVE_W-1:0]         moves;

  wire accept = start && !busy;
  assign busy = (state != S_IDLE);

  // border coordinates in fixed point
  logic [COORD_W-1:0] h_fx, w_fx;
  assign h_fx = {image_height, {FRAC_BITS{1'b0}}};
  assign w_fx = {image_width, {FRAC_BITS{1'b0}}};

  // segment deltas
  logic signed [COORD_W:0] dx, dy, dy_prev;
  logic [COORD_W:0]        sum_x;
  assign dx      = $signed({1'b0, cur_x}) - $signed({1'b0, prev_x});
  assign dy      = $signed({1'b0, cur_y}) - $signed({1'b0, prev_y});
  assign dy_prev = $signed({1'b0, prev_y}) - $signed({1'b0, cur_y});
  assign sum_x   = {1'b0, prev_x} + {1'b0, cur_x};

  // one border move from (prev_x, prev_y)
  logic [COORD_W-1:0]      nx, ny;
  logic signed [COORD_W:0] wleg;
  logic                    right_move;
  logic                    at_start;
  logic                    walk_end;

  always_comb begin
    nx = prev_x;
    ny = prev_y;
    right_move = 1'b0;
    priority if (prev_x == '0 && prev_y != h_fx) begin
      ny = (start_x == '0 && start_y > prev_y) ? start_y : h_fx;
      wleg = $signed({1'b0, ny}) - $signed({1'b0, prev_y});
    end else if (prev_y == h_fx && prev_x != w_fx) begin
      nx = (start_y == h_fx && start_x > prev_x) ? start_x : w_fx;
      wleg = $signed({1'b0, nx}) - $signed({1'b0, prev_x});
    end else if (prev_x == w_fx && prev_y != '0) begin
      ny = (start_x == w_fx && start_y < prev_y) ? start_y : '0;
      wleg = $signed({1'b0, prev_y}) - $signed({1'b0, ny});
      right_move = 1'b1;
    end else begin
      nx = (start_y == '0 && start_x < prev_x) ? start_x : '0;
      wleg = $signed({1'b0, prev_x}) - $signed({1'b0, nx});
    end
  end

  assign at_start = (prev_x == start_x) && (prev_y == start_y);
  assign walk_end = at_start || (moves == MAX_MOVES);

  // shared multiplier operand select
  logic signed [MUL_W-1:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DX: begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
      end
      S_DY: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
      end
      S_SH: begin
        mul_a = $signed({1'b0, sum_x});
        mul_b = MUL_W'(dy_prev);
      end
      S_WALK: begin
        mul_a = $signed({2'b00, w_fx});
        mul_b = MUL_W'(wleg);
      end
      S_IDLE, S_SQRT, S_LEN, S_WSHOE: ;
      default: ;
    endcase
  end

  // square-root step
  logic [SQ_W:0]            trial;
  logic                     take;
  logic                     round_up;
  logic signed [LEG_W-1:0]  sqrt_leg;

  assign trial    = {1'b0, root} + {1'b0, bitv};
  assign take     = ({1'b0, rem} >= trial);
  assign round_up = (rem > root);
  assign sqrt_leg = $signed({1'b0, root[LEG_W-2:0]}) + $signed(LEG_W'(round_up));

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      image_height   <= IMAGE_SIZE_RESET;
      image_width    <= IMAGE_SIZE_RESET;
      awaiting_first <= 1'b1;
      length_sum     <= '0;
      shoelace_sum   <= '0;
      start_x        <= '0;
      start_y        <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
      moves          <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_write) begin
        if (cfg_index == REG_IMAGE_HEIGHT) image_height <= cfg_data;
        else                               image_width  <= cfg_data;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_x    <= x_coord;
            cur_y    <= y_coord;
            cur_last <= last_vertex;
            moves    <= '0;
            if (awaiting_first) begin
              // first vertex: store it, clear the sums, no segment
              start_x        <= x_coord;
              start_y        <= y_coord;
              prev_x         <= x_coord;
              prev_y         <= y_coord;
              length_sum     <= '0;
              shoelace_sum   <= '0;
              awaiting_first <= 1'b0;
              if (last_vertex) state <= S_WALK;
            end else begin
              state <= S_DX;
            end
          end
        end
        S_DX: begin
          prod  <= mul_a * mul_b;
          state <= S_DY;
        end
        S_DY: begin
          prod  <= mul_a * mul_b;
          rem   <= prod[SQ_W-1:0];
          state <= S_SH;
        end
        S_SH: begin
          prod  <= mul_a * mul_b;
          rem   <= rem + prod[SQ_W-1:0];
          root  <= '0;
          bitv  <= {2'b01, {(SQ_W-2){1'b0}}};
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (take) begin
            rem  <= rem - trial[SQ_W-1:0];
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) state <= S_LEN;
        end
        S_LEN: begin
          // prod still holds the shoelace term of this segment
          length_sum   <= sat_len(length_sum, sqrt_leg);
          shoelace_sum <= sat_shoe(shoelace_sum, {prod[PROD_W-1], prod[SHOE_W-1:0]});
          prev_x       <= cur_x;
          prev_y       <= cur_y;
          state        <= cur_last ? S_WALK : S_IDLE;
        end
        S_WALK: begin
          if (walk_end) begin
            perimeter      <= length_sum;
            area           <= area_of(shoelace_sum);
            done           <= 1'b1;
            length_sum     <= '0;
            shoelace_sum   <= '0;
            start_x        <= '0;
            start_y        <= '0;
            prev_x         <= '0;
            prev_y         <= '0;
            awaiting_first <= 1'b1;
            state          <= S_IDLE;
          end else begin
            length_sum <= sat_len(length_sum, LEG_W'(wleg));
            prev_x     <= nx;
            prev_y     <= ny;
            moves      <= moves + 1'b1;
            if (right_move) begin
              prod  <= mul_a * mul_b;
              state <= S_WSHOE;
            end
          end
        end
        S_WSHOE: begin
          // right-edge term is 2 * width * drop
          shoelace_sum <= sat_shoe(shoelace_sum, {prod[SHOE_W-1:0], 1'b0});
          state        <= S_WALK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // the block is idle whenever a result is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // a vertex after the first always starts the segment work
  a_seg_busy: assert property (@(posedge clk) disable iff (rst)
      (accept && !awaiting_first) |=> (state == S_DX))
    else $error("segment request did not start the multiplier pass");

  // the border walk is bounded
  a_moves_bound: assert property (@(posedge clk) disable iff (rst) moves <= MAX_MOVES)
    else $error("border walk exceeded its move limit");

  // a result always leaves the block waiting for a new first vertex
  a_done_rearm: assert property (@(posedge clk) disable iff (rst)
      done |-> (awaiting_first && length_sum == '0 && shoelace_sum == '0))
    else $error("state not cleared after a result");
`endif

endmodule

FILE: bench/curve_measure_board_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the closed-curve measure bench: predicts perimeter and area per curve.
// Depends on bccm_pkg for the block's widths and the register indexes.
package curve_measure_board_pkg;
  import bccm_pkg::*;

  localparam longint LEN_TOP  = (64'sd1 << LEN_W) - 1;
  localparam longint SHOE_TOP = (64'sd1 << (SHOE_W - 1)) - 1;
  localparam longint SHOE_BOT = -(64'sd1 << (SHOE_W - 1));
  localparam longint AREA_TOP = (64'sd1 << (AREA_W - 1)) - 1;
  localparam longint AREA_BOT = -(64'sd1 << (AREA_W - 1));

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } vertex_t;

  typedef struct packed {
    logic [LEN_W-1:0]         perim;
    logic signed [AREA_W-1:0] area;
  } measure_t;

  class curve_measure_board;
    int unsigned rows, cols;
    longint first_x, first_y, last_x, last_y;
    longint len_acc, shoe_acc;
    bit fresh;
    measure_t pending[$];
    int errors, checked;

    function new();
      rows = 32'(IMAGE_SIZE_RESET);
      cols = 32'(IMAGE_SIZE_RESET);
      fresh = 1'b1;
      len_acc = 0;
      shoe_acc = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_register(logic idx, logic [CFG_W-1:0] value);
      if (idx == REG_IMAGE_HEIGHT) rows = 32'(value);
      else cols = 32'(value);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // floor(sqrt(s)), then one up when s sits nearer the next square
    function longint round_root(longint s);
      longint r, t;
      r = 0;
      for (int b = 17; b >= 0; b--) begin
        t = r | (64'sd1 << b);
        if (t * t <= s) r = t;
      end
      if (s - r * r > r) r = r + 1;
      return r;
    endfunction

    function void add_len(longint leg);
      len_acc = clip(len_acc + leg, 0, LEN_TOP);
    endfunction

    function void add_shoe(longint term);
      shoe_acc = clip(shoe_acc + term, SHOE_BOT, SHOE_TOP);
    endfunction

    // Close the curve counter-clockwise along the border, bounded move count.
    function void close_curve();
      longint hh, ww, px, py, nx, ny;
      hh = longint'(rows) << FRAC_BITS;
      ww = longint'(cols) << FRAC_BITS;
      px = last_x;
      py = last_y;
      for (int m = 0; m < int'(MAX_MOVES); m++) begin
        if (px == first_x && py == first_y) break;
        nx = px;
        ny = py;
        if (px == 0 && py != hh) begin
          ny = (first_x == 0 && first_y > py) ? first_y : hh;
          add_len(ny - py);
        end else if (py == hh && px != ww) begin
          nx = (first_y == hh && first_x > px) ? first_x : ww;
          add_len(nx - px);
        end else if (px == ww && py != 0) begin
          ny = (first_x == ww && first_y < py) ? first_y : 0;
          add_len(py - ny);
          add_shoe(2 * ww * (py - ny));
        end else begin
          nx = (first_y == 0 && first_x < px) ? first_x : 0;
          add_len(px - nx);
        end
        px = nx;
        py = ny;
      end
    endfunction

    function void take_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
      longint vx, vy, dx, dy, half;
      measure_t m;
      vx = longint'(x);
      vy = longint'(y);
      if (fresh) begin
        first_x = vx;
        first_y = vy;
        last_x = vx;
        last_y = vy;
        len_acc = 0;
        shoe_acc = 0;
        fresh = 1'b0;
      end else begin
        dx = vx - last_x;
        dy = vy - last_y;
        add_len(round_root(dx * dx + dy * dy));
        add_shoe((last_x + vx) * (last_y - vy));
        last_x = vx;
        last_y = vy;
      end
      if (!last) return;
      close_curve();
      half = clip(shoe_acc >>> 1, AREA_BOT, AREA_TOP);
      m.perim = len_acc[LEN_W-1:0];
      m.area = half[AREA_W-1:0];
      pending.push_back(m);
      first_x = 0;
      first_y = 0;
      last_x = 0;
      last_y = 0;
      len_acc = 0;
      shoe_acc = 0;
      fresh = 1'b1;
    endfunction

    function void check_measure(logic [LEN_W-1:0] p, logic signed [AREA_W-1:0] a);
      measure_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got perimeter %0d area %0d",
                 $time, p, a);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (p !== want.perim) begin
        errors++;
        $display("%0t: perimeter mismatch, expected %0d, got %0d", $time, want.perim, p);
      end
      if (a !== want.area) begin
        errors++;
        $display("%0t: area mismatch, expected %0d, got %0d", $time, want.area, a);
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Top-level bench for boundary_closed_curve_measure: drives vertex curves and image sizes.
// Depends on bccm_pkg and curve_measure_board_pkg (scoreboard and vertex type).
module tb_top;
  import bccm_pkg::*;
  import curve_measure_board_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 40;      // longer than the busy span of one vertex plus the full border walk
  localparam int CYCLE_LIMIT  = 400000;  // many times the slowest legal run
  localparam int RANDOM_ITEMS = 600;
  localparam int PHASES       = 8;
  localparam int COORD_TOP    = (1 << COORD_W) - 1;

  typedef enum int {CURVE_BORDER, CURVE_LOOP, CURVE_LAPS, CURVE_NOISE, CURVE_DOT} curve_kind_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [COORD_W-1:0]       x_coord;
  logic [COORD_W-1:0]       y_coord;
  logic                     last_vertex;
  logic                     cfg_write;
  logic                     cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     done;
  logic [LEN_W-1:0]         perimeter;
  logic signed [AREA_W-1:0] area;

  curve_measure_board board;
  vertex_t path[$];            // vertices of the curve being built
  int unsigned span_x, span_y; // right and bottom border in fixed point
  int sent, curves, sizes_used, cycles;
  bit quiet;                   // no idling on the current curve

  boundary_closed_curve_measure DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .last_vertex (last_vertex),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .perimeter   (perimeter),
    .area        (area)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycles, board.outstanding());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Results cannot be held off: take each one in the cycle its strobe is high.
  always @(posedge clk) begin
    if (!rst && done) board.check_measure(perimeter, area);
  end

  // Present one vertex and hold it until an edge sees start high and busy low.
  task automatic send_vertex(input vertex_t v);
    x_coord     <= v.x;
    y_coord     <= v.y;
    last_vertex <= v.last;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    board.take_vertex(v.x, v.y, v.last);
    sent++;
  endtask

  // Drop start for the requested gap; with n of zero the next request follows back to back.
  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Mostly short gaps, now and then one long enough to span a whole vertex.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Wait out every pending curve, then let the block fall fully idle.
  task automatic settle();
    start <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both image sizes on back-to-back cycles; only call while idle.
  task automatic set_image(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] w);
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.set_register(REG_IMAGE_HEIGHT, h);
    board.set_register(REG_IMAGE_WIDTH, w);
    span_y = int'(h) << FRAC_BITS;
    span_x = int'(w) << FRAC_BITS;
    sizes_used++;
  endtask

  function automatic void plot(input int x, input int y, input bit last);
    vertex_t v;
    v.x = COORD_W'(x);
    v.y = COORD_W'(y);
    v.last = last;
    path.push_back(v);
  endfunction

  // A point on one of the four borders; corners get picked on purpose now and then.
  function automatic vertex_t border_point(input bit last);
    vertex_t v;
    case ($urandom_range(0, 3))
      0: begin
        v.x = '0;
        v.y = COORD_W'($urandom_range(0, span_y));
      end
      1: begin
        v.x = COORD_W'(span_x);
        v.y = COORD_W'($urandom_range(0, span_y));
      end
      2: begin
        v.x = COORD_W'($urandom_range(0, span_x));
        v.y = '0;
      end
      default: begin
        v.x = COORD_W'($urandom_range(0, span_x));
        v.y = COORD_W'(span_y);
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      v.x = $urandom_range(0, 1) ? COORD_W'(span_x) : '0;
      v.y = $urandom_range(0, 1) ? COORD_W'(span_y) : '0;
    end
    v.last = last;
    return v;
  endfunction

  // Mostly inside the image, sometimes anywhere in the coordinate range.
  function automatic vertex_t inner_point();
    vertex_t v;
    if ($urandom_range(0, 6) == 0) begin
      v.x = COORD_W'($urandom_range(0, COORD_TOP));
      v.y = COORD_W'($urandom_range(0, COORD_TOP));
    end else begin
      v.x = COORD_W'($urandom_range(0, span_x));
      v.y = COORD_W'($urandom_range(0, span_y));
    end
    v.last = 1'b0;
    return v;
  endfunction

  // Pick a curve shape. Well-formed curves dominate: start and end on the border,
  // or end back on the start. Full-scale laps can drive the area and the shoelace sum into saturation;
  // noise and lone vertices cover the broken cases.
  task automatic build_curve();
    curve_kind_t kind;
    vertex_t head;
    int roll, n;
    bit rev;
    roll = $urandom_range(0, 99);
    if (roll < 55)      kind = CURVE_BORDER;
    else if (roll < 70) kind = CURVE_LOOP;
    else if (roll < 78) kind = CURVE_LAPS;
    else if (roll < 92) kind = CURVE_NOISE;
    else                kind = CURVE_DOT;
    case (kind)
      CURVE_BORDER: begin
        path.push_back(border_point(1'b0));
        n = $urandom_range(0, 6);
        repeat (n) path.push_back(inner_point());
        path.push_back(border_point(1'b1));
      end
      CURVE_LOOP: begin
        head = $urandom_range(0, 1) ? border_point(1'b0) : inner_point();
        path.push_back(head);
        n = $urandom_range(1, 6);
        repeat (n) path.push_back(inner_point());
        head.last = 1'b1;
        path.push_back(head);
      end
      CURVE_LAPS: begin
        // walk the corners of the full coordinate square, either direction
        n = $urandom_range(4, 24);
        rev = 1'($urandom_range(0, 1));
        for (int k = 0; k <= n; k++) begin
          case (rev ? (4 - k % 4) % 4 : k % 4)
            0: plot(COORD_TOP, COORD_TOP, k == n);
            1: plot(COORD_TOP, 0, k == n);
            2: plot(0, 0, k == n);
            default: plot(0, COORD_TOP, k == n);
          endcase
        end
      end
      CURVE_NOISE: begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          plot($urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP), k == n - 1);
      end
      default: begin
        head = $urandom_range(0, 1) ? border_point(1'b1) : inner_point();
        head.last = 1'b1;
        path.push_back(head);
      end
    endcase
  endtask

  // Send the built curve; a quarter of the curves go without any idling.
  task automatic run_curve();
    quiet = ($urandom_range(0, 3) == 0);
    foreach (path[i]) begin
      send_vertex(path[i]);
      idle_for(quiet ? 0 : pick_gap());
    end
    path.delete();
    curves++;
  endtask

  initial begin
    int goal;
    board = new();
    sent = 0;
    curves = 0;
    sizes_used = 1;
    span_x = int'(IMAGE_SIZE_RESET) << FRAC_BITS;
    span_y = int'(IMAGE_SIZE_RESET) << FRAC_BITS;
    rst         <= 1'b1;
    start       <= 1'b0;
    x_coord     <= '0;
    y_coord     <= '0;
    last_vertex <= 1'b0;
    cfg_write   <= 1'b0;
    cfg_index   <= REG_IMAGE_HEIGHT;
    cfg_data    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed curves at the reset image size (border at 4096).
    // Lone vertices, marked last at once: zero length, zero area.
    plot(0, 0, 1'b1);
    run_curve();
    plot(COORD_TOP, COORD_TOP, 1'b1);
    run_curve();
    // Closed triangle: ends on its start, no border walk.
    plot(16, 16, 1'b0);
    plot(4000, 16, 1'b0);
    plot(16, 4000, 1'b0);
    plot(16, 16, 1'b1);
    run_curve();
    // Left edge to top edge: walk left along the top, then down to the start.
    plot(0, 1000, 1'b0);
    plot(2000, 2000, 1'b0);
    plot(1500, 0, 1'b1);
    run_curve();
    // End on the right edge: the climb adds its area term.
    plot(0, 1000, 1'b0);
    plot(4096, 3000, 1'b1);
    run_curve();
    // End on the bottom edge, start higher up the right edge.
    plot(4096, 500, 1'b0);
    plot(100, 4096, 1'b1);
    run_curve();
    // End on the left edge: four moves round to a start on the top.
    plot(2000, 0, 1'b0);
    plot(0, 3000, 1'b1);
    run_curve();
    // End off the border: walked as if on the top edge.
    plot(100, 100, 1'b0);
    plot(200, 300, 1'b1);
    run_curve();
    // Full-scale laps push the area past its clamp.
    plot(COORD_TOP, COORD_TOP, 1'b0);
    repeat (2) begin
      plot(COORD_TOP, 0, 1'b0);
      plot(0, 0, 1'b0);
      plot(0, COORD_TOP, 1'b0);
      plot(COORD_TOP, COORD_TOP, 1'b0);
    end
    plot(COORD_TOP, 0, 1'b1);
    run_curve();

    // Random curves, one image size per phase: the reset size, then extremes with zero size among them.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: set_image(12'd1, 12'd1);
          2: set_image(12'd4095, 12'd4095);
          3: set_image(12'd0, 12'd0);
          4: set_image(12'd4095, 12'd1);
          5: set_image(12'd1, 12'd4095);
          default: set_image(CFG_W'($urandom_range(1, 4095)), CFG_W'($urandom_range(1, 4095)));
        endcase
      end
      goal = sent + RANDOM_ITEMS / PHASES;
      while (sent < goal) begin
        build_curve();
        run_curve();
      end
    end

    settle();
    $display("ran %0d vertices in %0d curves over %0d image sizes", sent, curves, sizes_used);
    $display("checked %0d measures, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
